// ----- src/sitda_pkg.sv -----
// Shared types, constants and the BCD shift-add-3 step for the integer to ASCII block.
`timescale 1ns / 1ps
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned MIN_W      = 4;
  localparam int unsigned BITS_STEP  = 4;
  localparam int unsigned CONV_STEPS = VALUE_W / BITS_STEP;
  localparam int unsigned STEP_CNT_W = $clog2(CONV_STEPS);
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);
  localparam logic [MIN_W-1:0]  MAX_DIGITS  = MIN_W'(NUM_DIGITS);
  localparam logic [MIN_W-1:0]  MIN_RESET   = MIN_W'(1);

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             emit;
    logic             emit_sign;
    logic             emit_last;
    logic [IDX_W-1:0] digit_sel;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] ndig;
    logic             out_free;
  } dp_status_t;

  // Four double-dabble iterations: add 3 to each digit >= 5, then shift one bit in.
  function automatic bcd_t bcd_step4(bcd_t b, logic [BITS_STEP-1:0] bits);
    bcd_t                      r;
    logic [NUM_DIGITS*4-1:0]   flat;
    r = b;
    for (int s = BITS_STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r[d] >= 4'd5) begin
          r[d] = r[d] + 4'd3;
        end
      end
      flat = r;
      flat = {flat[NUM_DIGITS*4-2:0], bits[s]};
      r    = flat;
    end
    return r;
  endfunction

endpackage

// ----- src/signed_int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//   channel   direction  handshake               payload
//   input     in         valid_i / stall_o       value_i (32b signed)
//   output    out        valid_o / stall_i       char_out_o (6b), last_char_o
//   config    in         cfg_valid_i/cfg_ready_o min_digits_i (4b)
//
// An item passes through an accept state, the 4-bit-per-cycle shift-add-3
// binary to BCD loop and a state that sizes the digit field, then leaves
// one character per cycle through the output register while the output
// does not stall; an item has 0 to 11 characters.
// stall_o is low only while the controller is idle; the last character of an
// item may still wait in the output register while the next item converts.
// Output stalls hold the output register and pause emission.
// Reset clears the controller, the output valid and sets min_digits to 1.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [sitda_pkg::CHAR_W-1:0]         char_out_o,
  output logic                                 last_char_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sitda_pkg::MIN_W-1:0]          min_digits_i
);

  sitda_pkg::dp_cmd_t    cmd;
  sitda_pkg::dp_status_t status;

  // Register writes are always taken; the user must write only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  sitda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  sitda_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .min_digits_i (min_digits_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .char_out_o   (char_out_o),
    .last_char_o  (last_char_o)
  );

endmodule

// ----- src/sitda_ctrl.sv -----
// Controller: sequences load, conversion steps, sign and digit emission.
`timescale 1ns / 1ps
module sitda_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  sitda_pkg::dp_status_t   status_i,
  output sitda_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e                              state_q;
  logic [sitda_pkg::STEP_CNT_W-1:0]    step_q;
  logic [sitda_pkg::IDX_W-1:0]         idx_q;

  assign stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.digit_sel = idx_q - sitda_pkg::IDX_W'(1);
    cmd_o.emit_last = (idx_q == sitda_pkg::IDX_W'(1));
    unique case (state_q)
      ST_IDLE:  cmd_o.load = valid_i;
      ST_CONV:  cmd_o.step = 1'b1;
      ST_PREP:  ;
      ST_SIGN: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_sign = 1'b1;
        cmd_o.emit_last = 1'b0;
      end
      ST_DIGIT: cmd_o.emit = status_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            state_q <= ST_CONV;
            step_q  <= '0;
          end
        end
        ST_CONV: begin
          step_q <= step_q + sitda_pkg::STEP_CNT_W'(1);
          if (step_q == sitda_pkg::STEP_CNT_W'(sitda_pkg::CONV_STEPS - 1)) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          idx_q <= status_i.ndig;
          if (status_i.neg) begin
            state_q <= ST_SIGN;
          end else if (status_i.ndig == '0) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (status_i.out_free) begin
            state_q <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (status_i.out_free) begin
            idx_q <= idx_q - sitda_pkg::IDX_W'(1);
            if (idx_q == sitda_pkg::IDX_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sitda_dp.sv -----
// Datapath: magnitude, BCD register, min-digits register and output register.
`timescale 1ns / 1ps
module sitda_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value_i,
  input  logic                                 cfg_we_i,
  input  logic [sitda_pkg::MIN_W-1:0]          min_digits_i,
  input  sitda_pkg::dp_cmd_t                   cmd_i,
  output sitda_pkg::dp_status_t                status_o,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [sitda_pkg::CHAR_W-1:0]         char_out_o,
  output logic                                 last_char_o
);

  logic [sitda_pkg::VALUE_W-1:0] mag_q;
  logic                          neg_q;
  sitda_pkg::bcd_t               bcd_q;
  logic [sitda_pkg::MIN_W-1:0]   min_q;
  logic                          out_valid_q;
  logic [sitda_pkg::CHAR_W-1:0]  char_q;
  logic                          last_q;

  logic [sitda_pkg::MIN_W-1:0]   min_cap;
  logic [sitda_pkg::IDX_W-1:0]   sig_digits;
  logic [sitda_pkg::VALUE_W-1:0] value_mag;

  // The magnitude of the most negative value, 2^31, still fits in 32 unsigned bits.
  assign value_mag = value_i[sitda_pkg::VALUE_W-1] ? (~value_i + 1'b1) : value_i;

  assign min_cap = (min_q > sitda_pkg::MAX_DIGITS) ? sitda_pkg::MAX_DIGITS : min_q;

  always_comb begin
    sig_digits = '0;
    for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
      if (bcd_q[d] != 4'd0) begin
        sig_digits = sitda_pkg::IDX_W'(d + 1);
      end
    end
  end

  assign status_o.neg      = neg_q;
  assign status_o.ndig     = (sig_digits > sitda_pkg::IDX_W'(min_cap)) ?
                             sig_digits : sitda_pkg::IDX_W'(min_cap);
  assign status_o.out_free = !out_valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= sitda_pkg::MIN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_q <= min_digits_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[sitda_pkg::VALUE_W-1];
      mag_q <= value_mag;
      bcd_q <= '0;
    end else if (cmd_i.step) begin
      bcd_q <= sitda_pkg::bcd_step4(bcd_q,
                 mag_q[sitda_pkg::VALUE_W-1 -: sitda_pkg::BITS_STEP]);
      mag_q <= {mag_q[sitda_pkg::VALUE_W-sitda_pkg::BITS_STEP-1:0],
                {sitda_pkg::BITS_STEP{1'b0}}};
    end
    if (cmd_i.emit) begin
      char_q <= cmd_i.emit_sign ? sitda_pkg::ASCII_MINUS :
                sitda_pkg::ASCII_ZERO + {2'b00, bcd_q[cmd_i.digit_sel]};
      last_q <= cmd_i.emit_last;
    end
  end

  assign valid_o     = out_valid_q;
  assign char_out_o  = char_q;
  assign last_char_o = last_q;

endmodule

// ----- src/sitda_chk.sv -----
// Port-level checker for the integer to ASCII block, with its bind.
`timescale 1ns / 1ps
module sitda_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 valid_i,
  input logic                                 stall_o,
  input logic                                 valid_o,
  input logic                                 stall_i,
  input logic [sitda_pkg::CHAR_W-1:0]         char_out_o,
  input logic                                 last_char_o
);

  // A stalled character stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output valid dropped under stall");

  // Only '-' or a digit is ever shown.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (char_out_o == sitda_pkg::ASCII_MINUS) ||
                ((char_out_o >= sitda_pkg::ASCII_ZERO) &&
                 (char_out_o <= sitda_pkg::ASCII_ZERO + 6'd9)))
    else $error("character out of range");

  // A sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (char_out_o == sitda_pkg::ASCII_MINUS) |-> !last_char_o)
    else $error("minus sign marked as last character");

  // One item at a time: an accepted item closes the input the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("input not stalled after accepting an item");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (valid_i),
  .stall_o     (stall_o),
  .valid_o     (valid_o),
  .stall_i     (stall_i),
  .char_out_o  (char_out_o),
  .last_char_o (last_char_o)
);
